>>> design/apct_pkg.sv
// ----------------------------------------------------------------------------
// apct_pkg
// Shared types and constants for the calibration pulse time correction block:
// table geometry, field widths, flag codes and configuration register indexes.
// ----------------------------------------------------------------------------
package apct_pkg;

    // table geometry (power-of-two sizes, index is {board, asic})
    localparam int NUM_BOARDS      = 64;
    localparam int ASICS_PER_BOARD = 4;
    localparam int TIME_FRAC_BITS  = 4;
    localparam int BOARD_W         = $clog2(NUM_BOARDS);
    localparam int ASIC_W          = $clog2(ASICS_PER_BOARD);
    localparam int TABLE_DEPTH     = NUM_BOARDS * ASICS_PER_BOARD;
    localparam int TABLE_AW        = BOARD_W + ASIC_W;

    // field widths
    localparam int CHAN_W = 3;
    localparam int TIME_W = 16;
    localparam int CORR_W = TIME_W + 1;
    localparam int FLAG_W = 2;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] CFG_CAL_CHANNEL      = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_LOW       = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_HIGH      = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_SECOND_PULSE_GAP = 2'd3;

    // register reset values, whole bins scaled to fixed point
    localparam logic [CHAN_W-1:0] CAL_CHANNEL_RST = 3'd7;
    localparam logic [TIME_W-1:0] WINDOW_LOW_RST  = TIME_W'(150 << TIME_FRAC_BITS);
    localparam logic [TIME_W-1:0] WINDOW_HIGH_RST = TIME_W'(400 << TIME_FRAC_BITS);
    localparam logic [TIME_W-1:0] GAP_RST         = TIME_W'(65 << TIME_FRAC_BITS);

    // result flag codes
    localparam logic [FLAG_W-1:0] FLAG_NONE   = 2'd0;
    localparam logic [FLAG_W-1:0] FLAG_CAL    = 2'd1;
    localparam logic [FLAG_W-1:0] FLAG_CAND   = 2'd2;
    localparam logic [FLAG_W-1:0] FLAG_SECOND = 2'd3;

    // item kinds
    localparam logic FUNC_SEARCH = 1'b0;
    localparam logic FUNC_APPLY  = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] cal_channel;
        logic [TIME_W-1:0] window_low;
        logic [TIME_W-1:0] window_high;
        logic [TIME_W-1:0] second_pulse_gap;
    } cfg_t;

endpackage

>>> design/apct_ref_ram.sv
// ----------------------------------------------------------------------------
// apct_ref_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module apct_ref_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/apct_cfg_regs.sv
// ----------------------------------------------------------------------------
// apct_cfg_regs
// Configuration register file: calibration channel, search window bounds and
// second pulse gap, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module apct_cfg_regs
    import apct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output cfg_t              cfg
);

    cfg_t cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cal_channel      <= CAL_CHANNEL_RST;
            cfg_reg.window_low       <= WINDOW_LOW_RST;
            cfg_reg.window_high      <= WINDOW_HIGH_RST;
            cfg_reg.second_pulse_gap <= GAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CAL_CHANNEL:      cfg_reg.cal_channel      <= cfg_wdata[CHAN_W-1:0];
                CFG_WINDOW_LOW:       cfg_reg.window_low       <= cfg_wdata[TIME_W-1:0];
                CFG_WINDOW_HIGH:      cfg_reg.window_high      <= cfg_wdata[TIME_W-1:0];
                CFG_SECOND_PULSE_GAP: cfg_reg.second_pulse_gap <= cfg_wdata[TIME_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/asic_cal_pulse_time_correction.sv
// ----------------------------------------------------------------------------
// asic_cal_pulse_time_correction
// Per-(board, asic) calibration pulse reference search and hit time
// correction, built around a reference time RAM with per-entry valid bits.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   hit      | in        | start && !busy        | func, first_in_event, board,
//            |           |                       | asic, channel, tdc_time,
//            |           |                       | is_candidate
//   result   | out       | done (one cycle)      | corrected_time, quality_ref,
//            |           |                       | flag_code
//   config   | in        | cfg_we                | cfg_addr, cfg_wdata
//
// The accept edge issues the RAM read; the next edge evaluates, writes the
// reference back and registers the result, so done rises in the cycle after
// the accept and busy covers the cycle between. No new hit is accepted while
// busy, as set by the RAM read-modify-write.
// Reset clears the valid bits at once; no clearing pass is needed. An item
// with first_in_event set clears all valid bits at its accept edge.
// The result receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module asic_cal_pulse_time_correction
    import apct_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // hit transaction
    input  logic                     start,
    output logic                     busy,
    input  logic                     func,
    input  logic                     first_in_event,
    input  logic [BOARD_W-1:0]       board,
    input  logic [ASIC_W-1:0]        asic,
    input  logic [CHAN_W-1:0]        channel,
    input  logic [TIME_W-1:0]        tdc_time,
    input  logic                     is_candidate,
    // result transaction
    output logic                     done,
    output logic signed [CORR_W-1:0] corrected_time,
    output logic [TIME_W-1:0]        quality_ref,
    output logic [FLAG_W-1:0]        flag_code,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CFG_DW-1:0]        cfg_wdata
);

    cfg_t cfg;

    logic                    accept;
    logic [TABLE_AW-1:0]     rd_idx;
    logic [TIME_W-1:0]       ram_rdata;

    // stage one: item waiting for its RAM read data
    logic                    s1_valid_reg;
    logic                    s1_func_reg;
    logic [TABLE_AW-1:0]     s1_idx_reg;
    logic [CHAN_W-1:0]       s1_chan_reg;
    logic [TIME_W-1:0]       s1_time_reg;
    logic                    s1_cand_reg;

    logic [TABLE_DEPTH-1:0]  valid_reg;

    // evaluation
    logic [TIME_W-1:0]       ref_t;
    logic                    on_cal;
    logic                    in_window;
    logic                    take_ref;
    logic                    ref_we;
    logic signed [CORR_W-1:0] corr;
    logic                    below_gap;

    logic                    done_reg;
    logic [CORR_W-1:0]       corr_reg;
    logic [CORR_W-1:0]       corr_next;
    logic [TIME_W-1:0]       qref_reg;
    logic [TIME_W-1:0]       qref_next;
    logic [FLAG_W-1:0]       flag_reg;
    logic [FLAG_W-1:0]       flag_next;

    apct_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // hit accept and table index
    assign accept = start && !s1_valid_reg;
    assign rd_idx = {board, asic};

    apct_ref_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (TIME_W)
    ) u_ram (
        .clk   (clk),
        .we    (ref_we),
        .waddr (s1_idx_reg),
        .wdata (s1_time_reg),
        .re    (accept),
        .raddr (rd_idx),
        .rdata (ram_rdata)
    );

    // stage one item capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_idx_reg  <= rd_idx;
            s1_chan_reg <= channel;
            s1_time_reg <= tdc_time;
            s1_cand_reg <= is_candidate;
        end
    end

    // valid bits: cleared at event start, set on reference write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (accept && first_in_event)
        begin
            valid_reg <= '0;
        end
        else if (ref_we)
        begin
            valid_reg[s1_idx_reg] <= 1'b1;
        end
    end

    // reference lookup and search decision
    always_comb
    begin
        ref_t     = valid_reg[s1_idx_reg] ? ram_rdata : '0;
        on_cal    = (s1_chan_reg == cfg.cal_channel);
        in_window = (s1_time_reg > cfg.window_low) && (s1_time_reg < cfg.window_high);
        take_ref  = on_cal && in_window && ((s1_time_reg < ref_t) || (ref_t == '0));
        ref_we    = s1_valid_reg && (s1_func_reg == FUNC_SEARCH) && take_ref;
        corr      = $signed({1'b0, s1_time_reg}) - $signed({1'b0, ref_t});
        below_gap = corr < $signed({1'b0, cfg.second_pulse_gap});
    end

    // result values
    always_comb
    begin
        if (s1_func_reg == FUNC_SEARCH)
        begin
            corr_next = '0;
            qref_next = '0;
            flag_next = take_ref ? FLAG_CAND : FLAG_NONE;
        end
        else
        begin
            corr_next = corr;
            qref_next = ref_t;
            flag_next = s1_cand_reg ? FLAG_CAND : FLAG_NONE;
            if (ref_t != '0)
            begin
                if (!s1_cand_reg)
                begin
                    flag_next = FLAG_CAL;
                end
                if (on_cal && below_gap)
                begin
                    flag_next = FLAG_SECOND;
                end
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            corr_reg <= corr_next;
            qref_reg <= qref_next;
            flag_reg <= flag_next;
        end
    end

    assign busy           = s1_valid_reg;
    assign done           = done_reg;
    assign corrected_time = $signed(corr_reg);
    assign quality_ref    = qref_reg;
    assign flag_code      = flag_reg;

    // every item in flight (busy) yields a result on the following edge
    a_busy_then_done : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("accepted hit produced no result");

    // no result without an item in flight
    a_done_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a hit in flight");

    // read-modify-write interlock: no back-to-back items
    a_interlock : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("second hit accepted during read-modify-write");

    // a held reference never leaves a hit unflagged
    a_ref_flagged : assert property (@(posedge clk) disable iff (!rst_n)
        (done && quality_ref != '0) |-> (flag_code != FLAG_NONE))
        else $error("hit with reference left unflagged");

endmodule

>>> tb/asic_cal_pulse_time_correction_test.sv
// ----------------------------------------------------------------------------
// asic_cal_pulse_time_correction_test
// Self-checking bench for the calibration pulse time correction block. Hits
// are sent as search and apply passes of whole events, with window, channel
// and gap boundaries hit directly, then random events under several register
// settings. A local model of the reference table predicts every result.
// ----------------------------------------------------------------------------
module asic_cal_pulse_time_correction_test;
    import apct_pkg::*;

    localparam int RANDOM_ITEMS = 1430;

    typedef struct packed {
        logic              func;
        logic              first;
        logic [BOARD_W-1:0] board;
        logic [ASIC_W-1:0] asic;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] tdc;
        logic              cand;
    } hit_t;

    typedef struct packed {
        logic [CORR_W-1:0] corr;
        logic [TIME_W-1:0] qref;
        logic [FLAG_W-1:0] flag;
    } corr_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic                     func = 1'b0;
    logic                     first_in_event = 1'b0;
    logic [BOARD_W-1:0]       board = '0;
    logic [ASIC_W-1:0]        asic = '0;
    logic [CHAN_W-1:0]        channel = '0;
    logic [TIME_W-1:0]        tdc_time = '0;
    logic                     is_candidate = 1'b0;
    logic                     done;
    logic signed [CORR_W-1:0] corrected_time;
    logic [TIME_W-1:0]        quality_ref;
    logic [FLAG_W-1:0]        flag_code;
    logic                     cfg_we = 1'b0;
    logic [CFG_AW-1:0]        cfg_addr = '0;
    logic [CFG_DW-1:0]        cfg_wdata = '0;

    // register copies and reference table of the model
    logic [CHAN_W-1:0] cal_chan_q = CAL_CHANNEL_RST;
    logic [TIME_W-1:0] win_lo_q   = WINDOW_LOW_RST;
    logic [TIME_W-1:0] win_hi_q   = WINDOW_HIGH_RST;
    logic [TIME_W-1:0] gap_q      = GAP_RST;
    logic [TIME_W-1:0] ref_table [TABLE_DEPTH];

    corr_result_t pending_corrections[$];
    int unsigned  errors = 0;
    int unsigned  items_sent = 0;
    bit           gaps_on = 1'b1;

    asic_cal_pulse_time_correction u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .first_in_event (first_in_event),
        .board          (board),
        .asic           (asic),
        .channel        (channel),
        .tdc_time       (tdc_time),
        .is_candidate   (is_candidate),
        .done           (done),
        .corrected_time (corrected_time),
        .quality_ref    (quality_ref),
        .flag_code      (flag_code),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        errors++;
        if (errors <= 10)
            $display("%t mismatch: %s", $realtime, msg);
    endtask

    // reference search and time correction for one hit, updates the table
    function automatic corr_result_t predict_correction(input hit_t h);
        corr_result_t      r;
        logic [TIME_W-1:0] ref_t;
        logic [7:0]        idx;
        logic              on_cal;
        if (h.first)
            foreach (ref_table[i])
                ref_table[i] = '0;
        idx    = {h.board, h.asic};
        ref_t  = ref_table[idx];
        on_cal = (h.channel == cal_chan_q);
        r      = '0;
        if (h.func == FUNC_SEARCH)
        begin
            r.flag = FLAG_NONE;
            if (on_cal && h.tdc > win_lo_q && h.tdc < win_hi_q
                && (h.tdc < ref_t || ref_t == '0))
            begin
                ref_table[idx] = h.tdc;
                r.flag = FLAG_CAND;
            end
        end
        else
        begin
            r.corr = {1'b0, h.tdc} - {1'b0, ref_t};
            r.qref = ref_t;
            r.flag = h.cand ? FLAG_CAND : FLAG_NONE;
            if (ref_t != '0)
            begin
                if (!h.cand)
                    r.flag = FLAG_CAL;
                if (on_cal && $signed(r.corr) < $signed({1'b0, gap_q}))
                    r.flag = FLAG_SECOND;
            end
        end
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        corr_result_t want;
        if (rst_n && done)
        begin
            if (pending_corrections.size() == 0)
                log_mismatch("result with no transaction outstanding");
            else
            begin
                want = pending_corrections.pop_front();
                if (corrected_time !== want.corr || quality_ref !== want.qref
                    || flag_code !== want.flag)
                    log_mismatch($sformatf(
                        "exp corr %0d qref %0d flag %0d, got corr %0d qref %0d flag %0d",
                        $signed(want.corr), want.qref, want.flag,
                        corrected_time, quality_ref, flag_code));
            end
        end
    end

    // drive one hit transaction, returns with start still high
    task automatic send_hit(input hit_t h, output corr_result_t r);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 29)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start          <= 1'b1;
        func           <= h.func;
        first_in_event <= h.first;
        board          <= h.board;
        asic           <= h.asic;
        channel        <= h.channel;
        tdc_time       <= h.tdc;
        is_candidate   <= h.cand;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r = predict_correction(h);
        pending_corrections.push_back(r);
        items_sent++;
    endtask

    task automatic stop_sending;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic wait_idle;
        while (pending_corrections.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_CAL_CHANNEL:      cal_chan_q = data[CHAN_W-1:0];
            CFG_WINDOW_LOW:       win_lo_q = data;
            CFG_WINDOW_HIGH:      win_hi_q = data;
            CFG_SECOND_PULSE_GAP: gap_q = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // all four registers, only with the block idle
    task automatic set_config(input logic [CFG_DW-1:0] cal, input logic [TIME_W-1:0] lo,
                              input logic [TIME_W-1:0] hi, input logic [TIME_W-1:0] gap);
        stop_sending();
        wait_idle();
        write_reg(CFG_CAL_CHANNEL, cal);
        write_reg(CFG_WINDOW_LOW, lo);
        write_reg(CFG_WINDOW_HIGH, hi);
        write_reg(CFG_SECOND_PULSE_GAP, gap);
    endtask

    function automatic hit_t mk_hit(input logic f, input int fst, input int b, input int a,
                                    input int ch, input int t, input int c);
        hit_t h;
        h.func    = f;
        h.first   = fst[0];
        h.board   = b[BOARD_W-1:0];
        h.asic    = a[ASIC_W-1:0];
        h.channel = ch[CHAN_W-1:0];
        h.tdc     = t[TIME_W-1:0];
        h.cand    = c[0];
        return h;
    endfunction

    function automatic hit_t random_hit;
        hit_t h;
        h = $bits(hit_t)'($urandom);
        h.tdc = TIME_W'($urandom);
        return h;
    endfunction

    // time at the window edges or strictly inside when the window is open
    function automatic logic [TIME_W-1:0] window_time;
        int unsigned lo;
        int unsigned hi;
        lo = 32'(win_lo_q);
        hi = 32'(win_hi_q);
        case ($urandom_range(9))
            0: return win_lo_q;
            1: return win_hi_q;
            default:
                if (hi > lo + 1)
                    return TIME_W'($urandom_range(hi - 1, lo + 1));
                else
                    return TIME_W'($urandom);
        endcase
    endfunction

    // boundaries of the window, channel, gap and table clear at reset settings
    task automatic test_directed;
        hit_t         hits[$];
        corr_result_t r;
        hits = '{
            mk_hit(FUNC_SEARCH, 1, 0, 0, 7, 2400, 0),
            mk_hit(FUNC_SEARCH, 0, 0, 0, 7, 6400, 0),
            mk_hit(FUNC_SEARCH, 0, 0, 0, 7, 2401, 0),
            mk_hit(FUNC_SEARCH, 0, 0, 0, 7, 3000, 1),
            mk_hit(FUNC_SEARCH, 0, 0, 0, 7, 2401, 0),
            mk_hit(FUNC_SEARCH, 0, 63, 3, 7, 6399, 0),
            mk_hit(FUNC_SEARCH, 0, 63, 3, 7, 5000, 0),
            mk_hit(FUNC_SEARCH, 0, 63, 3, 3, 3000, 0),
            mk_hit(FUNC_SEARCH, 0, 5, 1, 0, 65535, 1),
            mk_hit(FUNC_SEARCH, 0, 5, 1, 7, 0, 0),
            mk_hit(FUNC_APPLY, 0, 0, 0, 7, 2401, 1),
            mk_hit(FUNC_APPLY, 0, 0, 0, 7, 3441, 0),
            mk_hit(FUNC_APPLY, 0, 0, 0, 7, 3440, 0),
            mk_hit(FUNC_APPLY, 0, 0, 0, 7, 0, 0),
            mk_hit(FUNC_APPLY, 0, 0, 0, 2, 0, 0),
            mk_hit(FUNC_APPLY, 0, 63, 3, 5, 65535, 1),
            mk_hit(FUNC_APPLY, 0, 63, 3, 7, 65535, 0),
            mk_hit(FUNC_APPLY, 0, 5, 1, 7, 100, 0),
            mk_hit(FUNC_APPLY, 0, 5, 1, 7, 100, 1),
            mk_hit(FUNC_APPLY, 1, 0, 0, 4, 5000, 0),
            mk_hit(FUNC_SEARCH, 0, 0, 0, 7, 2402, 0),
            mk_hit(FUNC_APPLY, 0, 0, 0, 7, 2402, 1)
        };
        foreach (hits[i])
            send_hit(hits[i], r);
    endtask

    // one event: search pass on a few asics, then apply pass on the same hits
    task automatic run_event(input int unsigned n_search);
        hit_t         searched[$];
        logic [7:0]   keys[4];
        hit_t         h;
        corr_result_t r;
        int unsigned  n_keys;
        n_keys = $urandom_range(1, 4);
        foreach (keys[k])
            keys[k] = TABLE_AW'($urandom);
        for (int i = 0; i < n_search; i++)
        begin
            h = random_hit();
            h.func  = FUNC_SEARCH;
            h.first = (i == 0);
            if ($urandom_range(9) < 8)
                {h.board, h.asic} = keys[$urandom_range(n_keys - 1)];
            if ($urandom_range(9) < 6)
                h.channel = cal_chan_q;
            if ($urandom_range(9) < 7)
                h.tdc = window_time();
            send_hit(h, r);
            h.cand = (r.flag == FLAG_CAND);
            searched.push_back(h);
        end
        foreach (searched[i])
        begin
            h = searched[i];
            h.func  = FUNC_APPLY;
            h.first = 1'b0;
            if ($urandom_range(19) == 0)
                h.cand = ~h.cand;
            if ($urandom_range(7) == 0)
                h.tdc = TIME_W'($urandom);
            send_hit(h, r);
        end
    endtask

    // unstructured hits, the occasional one clearing the table
    task automatic noise_hits(input int unsigned n, input bit apply_only);
        hit_t         h;
        corr_result_t r;
        repeat (n)
        begin
            h = random_hit();
            h.first = ($urandom_range(19) == 0);
            if (apply_only)
                h.func = FUNC_APPLY;
            send_hit(h, r);
        end
    endtask

    // register extremes, empty and single-value windows
    task automatic test_register_extremes;
        set_config(16'd0, 16'd0, 16'hffff, 16'd0);
        run_event(20);
        run_event(12);
        set_config(16'hfff8 | 16'd7, 16'hffff, 16'd0, 16'hffff);
        run_event(16);
        set_config(16'd3, 16'd100, 16'd101, 16'd500);
        run_event(12);
        set_config(16'd5, 16'd100, 16'd102, 16'hffff);
        run_event(16);
        set_config(16'd2, 16'd0, 16'd2, 16'd0);
        run_event(12);
    endtask

    // random events under changing settings, one stretch with no gaps
    task automatic test_random_events;
        int unsigned goal;
        int unsigned n_ev;
        logic [TIME_W-1:0] lo;
        goal = items_sent + RANDOM_ITEMS;
        n_ev = 0;
        while (items_sent < goal)
        begin
            if (n_ev % 8 == 0)
            begin
                lo = TIME_W'($urandom_range(50000));
                set_config(CFG_DW'($urandom), lo, lo + TIME_W'($urandom_range(10000)),
                           ($urandom_range(9) == 0) ? 16'hffff
                                                    : TIME_W'($urandom_range(6000)));
            end
            else if ($urandom_range(15) == 0)
            begin
                stop_sending();
                wait_idle();
            end
            gaps_on = !(n_ev >= 16 && n_ev < 28);
            case ($urandom_range(9))
                0: noise_hits($urandom_range(5, 20), 1'b0);
                1: noise_hits($urandom_range(3, 10), 1'b1);
                default: run_event($urandom_range(4, 24));
            endcase
            n_ev++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        foreach (ref_table[i])
            ref_table[i] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_register_extremes();
        set_config(CFG_DW'(CAL_CHANNEL_RST), WINDOW_LOW_RST, WINDOW_HIGH_RST, GAP_RST);
        run_event(10);
        test_random_events();
        stop_sending();
        wait_idle();
        if (errors == 0 && pending_corrections.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
